// ===== src/aabb_affine_transform_core_defines.svh =====
`ifndef AABB_AFFINE_TRANSFORM_CORE_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_CORE_DEFINES_SVH

// clocked check, switched off while reset is high
`define AABB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define AABB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/aabb_pkg.sv =====
package aabb_pkg;

  // default datapath widths
  localparam int DEF_COORD_WIDTH    = 32;
  localparam int DEF_COEF_WIDTH     = 16;
  localparam int DEF_COEF_FRAC_BITS = 14;

  // configuration port geometry
  localparam int ROW_BITS        = 48;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = ROW_BITS;

  // pipeline controls handed to each axis slice
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic bypass;
  } pipe_ctrl_t;

endpackage

// ===== src/aabb_box_if.sv =====
interface aabb_box_if #(
  parameter int COORD_WIDTH = aabb_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic signed [COORD_WIDTH-1:0] extent_x;
  logic signed [COORD_WIDTH-1:0] extent_y;
  logic signed [COORD_WIDTH-1:0] extent_z;

  modport source (
    output valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
    output ready
  );
endinterface

// ===== src/aabb_result_if.sv =====
interface aabb_result_if #(
  parameter int COORD_WIDTH = aabb_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] new_center_x;
  logic signed [COORD_WIDTH-1:0] new_center_y;
  logic signed [COORD_WIDTH-1:0] new_center_z;
  logic signed [COORD_WIDTH-1:0] new_extent_x;
  logic signed [COORD_WIDTH-1:0] new_extent_y;
  logic signed [COORD_WIDTH-1:0] new_extent_z;
  logic                          input_invalid;

  modport source (
    output valid, new_center_x, new_center_y, new_center_z,
           new_extent_x, new_extent_y, new_extent_z, input_invalid,
    input  ready
  );
  modport sink (
    input  valid, new_center_x, new_center_y, new_center_z,
           new_extent_x, new_extent_y, new_extent_z, input_invalid,
    output ready
  );
endinterface

// ===== src/aabb_cfg_if.sv =====
interface aabb_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [aabb_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [aabb_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== src/aabb_axis.sv =====
module aabb_axis #(
  parameter int COORD_WIDTH    = aabb_pkg::DEF_COORD_WIDTH,
  parameter int COEF_WIDTH     = aabb_pkg::DEF_COEF_WIDTH,
  parameter int COEF_FRAC_BITS = aabb_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  aabb_pkg::pipe_ctrl_t          ctrl,
  input  logic signed [COEF_WIDTH-1:0]  coef [3],
  input  logic signed [COORD_WIDTH-1:0] center [3],
  input  logic signed [COORD_WIDTH-1:0] extent [3],
  input  logic signed [COORD_WIDTH-1:0] offset,
  input  logic signed [COORD_WIDTH-1:0] center_own,
  input  logic signed [COORD_WIDTH-1:0] extent_own,
  output logic signed [COORD_WIDTH-1:0] new_center,
  output logic signed [COORD_WIDTH-1:0] new_extent
);
  import aabb_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int KW = COEF_WIDTH;
  localparam int F  = COEF_FRAC_BITS;
  localparam int PW = KW + CW;
  localparam int SW = ((KW + CW > CW + F) ? KW + CW : CW + F) + 3;
  localparam int SH = SW - F;

  localparam logic signed [SW-1:0] HALF = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // clamp a shifted sum to the coordinate range
  function automatic logic signed [CW-1:0] sat(input logic signed [SH-1:0] v);
    logic [SH-CW:0] upper;
    upper = v[SH-1:CW-1];
    if ((&upper) || !(|upper)) begin
      return v[CW-1:0];
    end
    return v[SH-1] ? SAT_MIN : SAT_MAX;
  endfunction

  logic signed [PW-1:0] prod_c_next [3];
  logic signed [PW:0]   prod_e_next [3];
  logic signed [KW:0]   mag [3];
  logic signed [SW-1:0] base_next;
  logic signed [CW:0]   ct_next;

  logic signed [PW-1:0] prod_c [3];
  logic signed [PW:0]   prod_e [3];
  logic signed [SW-1:0] base;
  logic signed [CW:0]   ct1;
  logic signed [CW-1:0] ext1;

  logic signed [SW-1:0] sum_c_next;
  logic signed [SW-1:0] sum_e_next;
  logic signed [SW-1:0] sum_c;
  logic signed [SW-1:0] sum_e;
  logic signed [CW:0]   ct2;
  logic signed [CW-1:0] ext2;

  // products of each coefficient with center, and of its magnitude with extent
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = coef[i][KW-1] ? -{coef[i][KW-1], coef[i]} : {coef[i][KW-1], coef[i]};
      prod_c_next[i] = coef[i] * center[i];
      prod_e_next[i] = mag[i] * extent[i];
    end
    base_next = {{(SW-CW-F){offset[CW-1]}}, offset, {F{1'b0}}} + HALF;
    ct_next   = {center_own[CW-1], center_own} + {offset[CW-1], offset};
  end

  // stage 1: products registered
  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      prod_c <= prod_c_next;
      prod_e <= prod_e_next;
      base   <= base_next;
      ct1    <= ct_next;
      ext1   <= extent_own;
    end
  end

  // sums for center and half size, rounding term included
  always_comb begin
    sum_c_next = base;
    sum_e_next = HALF;
    for (int i = 0; i < 3; i++) begin
      sum_c_next = sum_c_next + {{(SW-PW){prod_c[i][PW-1]}}, prod_c[i]};
      sum_e_next = sum_e_next + {{(SW-PW-1){prod_e[i][PW]}}, prod_e[i]};
    end
  end

  // stage 2: sums registered
  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      sum_c <= sum_c_next;
      sum_e <= sum_e_next;
      ct2   <= ct1;
      ext2  <= ext1;
    end
  end

  // stage 3: scale back, clamp, select translate-only path
  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      if (ctrl.bypass) begin
        new_center <= sat({{(SH-CW-1){ct2[CW]}}, ct2});
        new_extent <= ext2;
      end else begin
        new_center <= sat(sum_c[SW-1:F]);
        new_extent <= sat(sum_e[SW-1:F]);
      end
    end
  end

endmodule

// ===== src/aabb_affine_transform_core.sv =====
// channel  | modport | moves per transaction
// ---------+---------+------------------------------------------------
// cfg      | sink    | register index and write data
// box      | sink    | center_x/y/z and extent_x/y/z of one box
// result   | source  | new center, new half sizes, input_invalid flag
//
// one box per cycle while the result side takes them; each result passes four registers
// (input register, product register, sum register, result register)
// rst is synchronous: stage valids clear, matrix goes to identity, offsets to zero
// a stalled result holds its stage; empty stages behind it still fill, so
// box.ready drops only once all four stages hold a box
// cfg.ready is always high; writes are meant for an empty pipe
module aabb_affine_transform_core #(
  parameter int COORD_WIDTH    = aabb_pkg::DEF_COORD_WIDTH,
  parameter int COEF_WIDTH     = aabb_pkg::DEF_COEF_WIDTH,
  parameter int COEF_FRAC_BITS = aabb_pkg::DEF_COEF_FRAC_BITS
) (
  input logic    clk,
  input logic    rst,
  aabb_cfg_if.sink      cfg,
  aabb_box_if.sink      box,
  aabb_result_if.source result
);
  import aabb_pkg::*;

`include "aabb_affine_transform_core_defines.svh"

  localparam int CW = COORD_WIDTH;
  localparam int KW = COEF_WIDTH;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_ROW_0,
    CFG_ROW_1,
    CFG_ROW_2,
    CFG_OFFSET_X,
    CFG_OFFSET_Y,
    CFG_OFFSET_Z
  } cfg_reg_t;

  // identity row: one at diagonal element, bits past the register dropped
  function automatic logic [ROW_BITS-1:0] row_reset(input int row);
    logic [ROW_BITS+3*KW-1:0] w;
    w = '0;
    w[row*KW + COEF_FRAC_BITS] = 1'b1;
    return w[ROW_BITS-1:0];
  endfunction

  logic [ROW_BITS-1:0]     matrix_row [3];
  logic signed [CW-1:0]    offset [3];
  logic [ROW_BITS+3*KW-1:0] row_ext [3];
  logic signed [KW-1:0]    coef_col [3][3];

  logic signed [CW-1:0] c0 [3];
  logic signed [CW-1:0] e0 [3];
  logic v0, v1, v2, v3;
  logic inv0, inv1, inv2, inv3;
  logic en0, en1, en2, en3;
  pipe_ctrl_t ctrl;

  logic signed [CW-1:0] new_ctr [3];
  logic signed [CW-1:0] new_ext [3];
  logic                 out_neg_ext;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        matrix_row[i] <= row_reset(i);
        offset[i]     <= '0;
      end
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_ROW_0:    matrix_row[0] <= cfg.data[ROW_BITS-1:0];
        CFG_ROW_1:    matrix_row[1] <= cfg.data[ROW_BITS-1:0];
        CFG_ROW_2:    matrix_row[2] <= cfg.data[ROW_BITS-1:0];
        CFG_OFFSET_X: offset[0]     <= cfg.data[CW-1:0];
        CFG_OFFSET_Y: offset[1]     <= cfg.data[CW-1:0];
        CFG_OFFSET_Z: offset[2]     <= cfg.data[CW-1:0];
        default: ;
      endcase
    end
  end

  // unpack coefficients: column j feeds output axis j
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_ext[i] = {{(3*KW){1'b0}}, matrix_row[i]};
      for (int j = 0; j < 3; j++) begin
        coef_col[j][i] = row_ext[i][j*KW +: KW];
      end
    end
  end

  // per-stage load enables; a stage fills when empty or when it drains
  assign en3 = !v3 || result.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign box.ready = en0;

  assign inv0 = e0[0][CW-1] || e0[1][CW-1] || e0[2][CW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= box.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // input register and invalid-box flag along the pipe
  always_ff @(posedge clk) begin
    if (en0) begin
      c0[0] <= box.center_x;
      c0[1] <= box.center_y;
      c0[2] <= box.center_z;
      e0[0] <= box.extent_x;
      e0[1] <= box.extent_y;
      e0[2] <= box.extent_z;
    end
    if (en1) inv1 <= inv0;
    if (en2) inv2 <= inv1;
    if (en3) inv3 <= inv2;
  end

  assign ctrl = '{ld1: en1, ld2: en2, ld3: en3, bypass: inv2};

  // one slice per output axis
  for (genvar j = 0; j < 3; j++) begin : g_axis
    aabb_axis #(
      .COORD_WIDTH   (COORD_WIDTH),
      .COEF_WIDTH    (COEF_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_axis (
      .clk       (clk),
      .ctrl      (ctrl),
      .coef      (coef_col[j]),
      .center    (c0),
      .extent    (e0),
      .offset    (offset[j]),
      .center_own(c0[j]),
      .extent_own(e0[j]),
      .new_center(new_ctr[j]),
      .new_extent(new_ext[j])
    );
  end

  // result channel
  assign result.valid         = v3;
  assign result.new_center_x  = new_ctr[0];
  assign result.new_center_y  = new_ctr[1];
  assign result.new_center_z  = new_ctr[2];
  assign result.new_extent_x  = new_ext[0];
  assign result.new_extent_y  = new_ext[1];
  assign result.new_extent_z  = new_ext[2];
  assign result.input_invalid = inv3;

  // any negative half size on the result
  assign out_neg_ext = new_ext[0][CW-1] || new_ext[1][CW-1] || new_ext[2][CW-1];

  // checks
  `AABB_ASSERT_RST(a_reset_empties, rst |=> !v3, "result valid right after reset")
  `AABB_ASSERT(a_ready_when_drained, !v3 |-> box.ready, "input stalled with empty output")
  `AABB_ASSERT(a_invalid_has_neg_extent, v3 && inv3 |-> out_neg_ext, "invalid box, no negative extent")
  `AABB_ASSERT(a_valid_extent_nonneg, v3 && !inv3 |-> !out_neg_ext, "negative extent from valid box")

endmodule

// ===== verif/aabb_transform_checker.sv =====
`timescale 1ns / 100ps

module aabb_transform_checker (
  input  logic   clk,
  input  logic   rst,
  aabb_cfg_if    cfg,
  aabb_box_if    box,
  aabb_result_if result,
  output int     errors,
  output int     pending
);
  import aabb_pkg::*;

  localparam int CW = DEF_COORD_WIDTH;
  localparam int KW = DEF_COEF_WIDTH;
  localparam int KF = DEF_COEF_FRAC_BITS;
  localparam longint SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam longint SAT_LO = -SAT_HI - 64'sd1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ROW_0,
    REG_ROW_1,
    REG_ROW_2,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z
  } reg_index_e;

  // fields 0..2 centre, 3..5 half sizes, 6 invalid flag
  typedef logic [6:0][CW-1:0] transform_t;
  typedef logic [5:0][CW-1:0] box_t;

  logic [ROW_BITS-1:0]    row_reg    [3];
  logic signed [CW-1:0]   offset_reg [3];
  transform_t             expected_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic string field_name(input int k);
    case (k)
      0: return "new_center_x";
      1: return "new_center_y";
      2: return "new_center_z";
      3: return "new_extent_x";
      4: return "new_extent_y";
      5: return "new_extent_z";
      default: return "input_invalid";
    endcase
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input longint v);
    longint s;
    s = v;
    if (s > SAT_HI) s = SAT_HI;
    if (s < SAT_LO) s = SAT_LO;
    return s[CW-1:0];
  endfunction

  // bounding box of the mapped box, exact sums then round and saturate
  function automatic transform_t transform_box(input box_t b);
    transform_t          r;
    longint              c [3];
    longint              e [3];
    longint              t, lo, hi, m, pa, pb;
    logic signed [KW-1:0] k;
    bit                  bad;
    bad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($signed(b[i]));
      e[i] = longint'($signed(b[3+i]));
      if (e[i] < 0) bad = 1'b1;
    end
    if (bad) begin
      // translate the centre only, half sizes pass through
      for (int j = 0; j < 3; j++) begin
        r[j]   = clamp_coord(c[j] + longint'(offset_reg[j]));
        r[3+j] = b[3+j];
      end
      r[6] = CW'(1);
      return r;
    end
    for (int j = 0; j < 3; j++) begin
      t  = longint'(offset_reg[j]);
      lo = t * (64'sd1 <<< KF);
      hi = lo;
      for (int i = 0; i < 3; i++) begin
        k  = row_reg[i][KW*j +: KW];
        m  = longint'(k);
        pa = m * (c[i] - e[i]);
        pb = m * (c[i] + e[i]);
        if (m >= 0) begin
          lo = lo + pa;
          hi = hi + pb;
        end else begin
          lo = lo + pb;
          hi = hi + pa;
        end
      end
      r[j]   = clamp_coord((lo + hi + (64'sd1 <<< KF)) >>> (KF + 1));
      r[3+j] = clamp_coord((hi - lo + (64'sd1 <<< KF)) >>> (KF + 1));
    end
    r[6] = '0;
    return r;
  endfunction

  // watch all three channels at the rising edge
  always @(posedge clk) begin : monitor
    transform_t got;
    transform_t want;
    box_t       b;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        row_reg[i]    = ROW_BITS'(1) << (KW * i + KF);
        offset_reg[i] = '0;
      end
      expected_q.delete();
    end else begin
      // result transaction against the oldest prediction
      if (result.valid && result.ready) begin
        got[0] = result.new_center_x;
        got[1] = result.new_center_y;
        got[2] = result.new_center_z;
        got[3] = result.new_extent_x;
        got[4] = result.new_extent_y;
        got[5] = result.new_extent_z;
        got[6] = CW'(result.input_invalid);
        if (expected_q.size() == 0) begin
          $display("%0t: result with no box outstanding: %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          for (int k = 0; k < 7; k++) begin
            if (got[k] !== want[k]) begin
              $display("%0t: %s expected %h got %h", $time, field_name(k), want[k], got[k]);
              errors++;
            end
          end
        end
      end
      // box transaction, predicted with the settings in force before this edge
      if (box.valid && box.ready) begin
        b[0] = box.center_x;
        b[1] = box.center_y;
        b[2] = box.center_z;
        b[3] = box.extent_x;
        b[4] = box.extent_y;
        b[5] = box.extent_z;
        expected_q.push_back(transform_box(b));
      end
      // register write, unknown indexes dropped
      if (cfg.valid && cfg.ready) begin
        case (reg_index_e'(cfg.index))
          REG_ROW_0:    row_reg[0]    = cfg.data;
          REG_ROW_1:    row_reg[1]    = cfg.data;
          REG_ROW_2:    row_reg[2]    = cfg.data;
          REG_OFFSET_X: offset_reg[0] = cfg.data[CW-1:0];
          REG_OFFSET_Y: offset_reg[1] = cfg.data[CW-1:0];
          REG_OFFSET_Z: offset_reg[2] = cfg.data[CW-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import aabb_pkg::*;

  localparam int CW          = DEF_COORD_WIDTH;
  localparam int KW          = DEF_COEF_WIDTH;
  localparam int NUM_REGS    = 6;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [CW-1:0] C_MAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_MIN   = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] C_NEG1  = '1;
  localparam logic [KW-1:0] K_ONE   = KW'(1) << DEF_COEF_FRAC_BITS;
  localparam logic [KW-1:0] K_NEG1  = -(KW'(1) << DEF_COEF_FRAC_BITS);
  localparam logic [KW-1:0] K_MAX   = {1'b0, {(KW-1){1'b1}}};
  localparam logic [KW-1:0] K_MIN   = {1'b1, {(KW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   cycles        = 0;
  int   send_idle_pct = 0;
  int   take_idle_pct = 0;
  int   hold_request  = 0;
  int   hold_left     = 0;
  int   boxes_sent    = 0;
  int   invalid_sent  = 0;
  int   settings_used = 0;
  logic [ROW_BITS-1:0] setting [NUM_REGS];

  aabb_cfg_if    cfg_ch ();
  aabb_box_if    box_ch ();
  aabb_result_if res_ch ();

  aabb_affine_transform_core uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .box    (box_ch),
    .result (res_ch)
  );

  aabb_transform_checker chk (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .box     (box_ch),
    .result  (res_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[aabb_affine_transform_core] ERROR");
      $finish;
    end
  end

  // result side: random back-pressure and requested long hold-offs
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= (int'($urandom_range(99)) >= take_idle_pct);
      end
    end
  end

  // mostly small values, some full range and some rails
  function automatic logic [CW-1:0] pick_coord();
    int r;
    r = int'($urandom_range(15));
    if (r < 4) return CW'($urandom);
    if (r == 4) return C_MAX;
    if (r == 5) return C_MIN;
    if (r < 11) return CW'(int'($urandom_range(1 << 22)) - (1 << 21));
    return CW'(int'($urandom_range(1 << 28)) - (1 << 27));
  endfunction

  function automatic logic [KW-1:0] corner_coef();
    case ($urandom_range(4))
      0: return K_MIN;
      1: return K_MAX;
      2: return K_ONE;
      3: return K_NEG1;
      default: return '0;
    endcase
  endfunction

  task automatic send_box(input logic [CW-1:0] cx, cy, cz, ex, ey, ez);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      box_ch.valid <= 1'b0;
      @(negedge clk);
    end
    box_ch.valid    <= 1'b1;
    box_ch.center_x <= cx;
    box_ch.center_y <= cy;
    box_ch.center_z <= cz;
    box_ch.extent_x <= ex;
    box_ch.extent_y <= ey;
    box_ch.extent_z <= ez;
    do @(posedge clk); while (!box_ch.ready);
    @(negedge clk);
    boxes_sent++;
    if (ex[CW-1] || ey[CW-1] || ez[CW-1]) invalid_sent++;
  endtask

  task automatic send_random_box();
    logic [CW-1:0] e [3];
    for (int k = 0; k < 3; k++) e[k] = pick_coord() & ~C_MIN;
    // roughly one box in ten carries a negative half size
    if ($urandom_range(9) == 0) e[$urandom_range(2)] = pick_coord() | C_MIN;
    if ($urandom_range(49) == 0) begin
      for (int k = 0; k < 3; k++) e[k] = e[k] | C_MIN;
    end
    send_box(pick_coord(), pick_coord(), pick_coord(), e[0], e[1], e[2]);
  endtask

  // stop offering boxes until every transaction has come back
  task automatic drain_boxes();
    box_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [ROW_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_INDEX_WIDTH'(idx);
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // load the whole setting while idle, optionally poking unused indexes too
  task automatic apply_setting(input bit stray);
    drain_boxes();
    for (int k = 0; k < NUM_REGS; k++) write_reg(k, setting[k]);
    if (stray) begin
      for (int k = NUM_REGS; k < (1 << CFG_INDEX_WIDTH); k++)
        write_reg(k, ROW_BITS'({$urandom, $urandom}));
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_setting();
    for (int k = 0; k < 3; k++) setting[k] = ROW_BITS'({$urandom, $urandom});
    for (int k = 3; k < NUM_REGS; k++) setting[k] = {KW'($urandom), pick_coord()};
  endtask

  task automatic corner_setting();
    for (int k = 0; k < 3; k++) setting[k] = {corner_coef(), corner_coef(), corner_coef()};
    for (int k = 3; k < NUM_REGS; k++) begin
      case ($urandom_range(3))
        0: setting[k] = {{KW{1'b0}}, C_MAX};
        1: setting[k] = {{KW{1'b1}}, C_MIN};
        2: setting[k] = '0;
        default: setting[k] = {KW'($urandom), pick_coord()};
      endcase
    end
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random_box();
  endtask

  initial begin
    box_ch.valid    <= 1'b0;
    box_ch.center_x <= '0;
    box_ch.center_y <= '0;
    box_ch.center_z <= '0;
    box_ch.extent_x <= '0;
    box_ch.extent_y <= '0;
    box_ch.extent_z <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 23;
    take_idle_pct = 65;

    // reset matrix: rails, zero and full half sizes, rounding, invalid boxes
    send_box(0, 0, 0, 0, 0, 0);
    send_box(C_MAX, C_MAX, C_MAX, 0, 0, 0);
    send_box(C_MIN, C_MIN, C_MIN, 0, 0, 0);
    send_box(0, 0, 0, C_MAX, C_MAX, C_MAX);
    send_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    send_box(1, C_NEG1, 1, 1, 1, 1);
    send_box(5, 7, 9, C_NEG1, 0, 0);
    send_box(C_MAX, C_MIN, 5, 3, C_MIN, 0);
    send_box(C_MAX, C_MAX, C_MAX, 0, 0, C_NEG1);

    // most negative coefficients, offsets on the rails and zero, unused indexes written
    setting[0] = {K_MIN, K_MIN, K_MIN};
    setting[1] = {K_MIN, K_MIN, K_MIN};
    setting[2] = {K_MIN, K_MIN, K_MIN};
    setting[3] = {{KW{1'b0}}, C_MAX};
    setting[4] = {{KW{1'b1}}, C_MIN};
    setting[5] = '0;
    apply_setting(1'b1);
    send_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_box(C_MIN, C_MIN, C_MIN, 0, 0, 0);
    send_box(1, 1, 1, 0, 0, 0);
    send_box(C_MAX, C_MIN, 0, C_NEG1, 0, 0);
    send_box(0, 0, 0, 0, 0, C_MIN);

    // largest positive coefficients, mixed offsets
    setting[0] = {K_MAX, K_MAX, K_MAX};
    setting[1] = {K_MAX, K_MAX, K_MAX};
    setting[2] = {K_MAX, K_MAX, K_MAX};
    setting[3] = {{KW{1'b1}}, C_MIN};
    setting[4] = {{KW{1'b1}}, C_NEG1};
    setting[5] = ROW_BITS'(1);
    apply_setting(1'b0);
    send_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    send_box(C_MAX, C_MAX, C_MAX, 0, 0, 0);
    send_box(0, 0, 0, 0, 0, 0);
    send_box(1, C_NEG1, 1, 1, 1, 1);
    send_box(C_MIN, C_MIN, C_MIN, C_NEG1, C_NEG1, C_NEG1);

    // random traffic, sender idling lightly and receiver heavily
    random_setting();
    apply_setting(1'b0);
    run_random(125);
    corner_setting();
    apply_setting(1'b1);
    run_random(125);

    // roles swapped, with a full drain halfway through
    send_idle_pct = 65;
    take_idle_pct = 23;
    random_setting();
    apply_setting(1'b0);
    run_random(60);
    drain_boxes();
    run_random(65);
    setting[0] = '0;
    setting[1] = '0;
    setting[2] = '0;
    for (int k = 3; k < NUM_REGS; k++) setting[k] = {KW'($urandom), pick_coord()};
    apply_setting(1'b0);
    run_random(125);

    // no idling; one long result hold-off while boxes keep coming
    send_idle_pct = 0;
    take_idle_pct = 0;
    random_setting();
    apply_setting(1'b0);
    hold_request = 120;
    run_random(125);
    corner_setting();
    apply_setting(1'b0);
    run_random(125);

    drain_boxes();
    repeat (10) @(posedge clk);
    $display("%0d boxes sent (%0d with a negative half size) under %0d register settings",
             boxes_sent, invalid_sent, settings_used);
    $display("both sides stalled at random, plus one long result hold-off and one drain");
    if (errors == 0) begin
      $display("[aabb_affine_transform_core] OK");
    end else begin
      $display("[aabb_affine_transform_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== aabb_affine_transform_core.f =====
+incdir+src
src/aabb_pkg.sv
src/aabb_box_if.sv
src/aabb_result_if.sv
src/aabb_cfg_if.sv
src/aabb_axis.sv
src/aabb_affine_transform_core.sv
verif/aabb_transform_checker.sv
verif/tb_top.sv
